@@ src/serial_boot_loader_protocol_assert.svh @@
// Assertion macros for the serial boot loader protocol engine.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef SERIAL_BOOT_LOADER_PROTOCOL_ASSERT_SVH
`define SERIAL_BOOT_LOADER_PROTOCOL_ASSERT_SVH
`ifndef SYNTHESIS
`define SLBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbp assertion failed");
`define SLBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbp assertion failed");
`else
`define SLBP_ASSERT_IMP(lbl, ante, cons)
`define SLBP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/slbp_pkg.sv @@
// Shared types, constants and the identification ROM of the boot loader engine.
// No dependencies; used by slbp_ctrl, slbp_dp and the top level.
package slbp_pkg;

  localparam int PAGE_WORDS   = 64;
  localparam int PAGE_COUNT   = 256;
  localparam int IDENT_LENGTH = 32;

  localparam int ROM_DEPTH   = 32;
  localparam int ROM_BITS    = ROM_DEPTH * 8;
  localparam int ID_W        = $clog2(ROM_DEPTH);
  localparam int IDENT_LIMIT = (IDENT_LENGTH < ROM_DEPTH) ? IDENT_LENGTH : ROM_DEPTH;
  localparam int WORD_W      = $clog2(PAGE_WORDS);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int PAGE_BYTES  = PAGE_WORDS * 2;
  localparam int ADDR_W      = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_COUNT  = 2'd2;

  localparam logic [15:0] PROBE_WINDOW_RST = 16'd1152;
  localparam logic [15:0] COMMAND_WAIT_RST = 16'd5760;
  localparam logic [7:0]  RETRY_COUNT_RST  = 8'd30;

  localparam logic [7:0] CH_PROBE = 8'h3f;  // '?'
  localparam logic [7:0] CH_ACK   = 8'h75;  // 'u'
  localparam logic [7:0] CH_IDENT = 8'h69;  // 'i'
  localparam logic [7:0] CH_WRITE = 8'h77;  // 'w'
  localparam logic [7:0] CH_PAGE  = 8'h40;  // '@'

  // Identification string, first byte in the top bits, zero padded.
  localparam logic [ROM_BITS-1:0] IDENT_ROM =
    {8'h0d, 8'h0a, "&128,32768,m32,16000000,1*", 8'h0d, 8'h0a, 16'h0000};

  localparam logic IDENT_EMPTY = (IDENT_ROM[ROM_BITS-1 -: 8] == 8'h00);

  typedef enum logic [2:0] {
    K_SEND  = 3'd0,
    K_ERASE = 3'd1,
    K_FILL  = 3'd2,
    K_WRITE = 3'd3,
    K_RWW   = 3'd4,
    K_RUN   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    BS_NONE,
    BS_PROBE,
    BS_PAGE,
    BS_IDENT
  } bsrc_t;

  typedef struct packed {
    logic  emit;
    kind_t kind;
    bsrc_t bsrc;
    logic  last;
    logic  tmr_dec;
    logic  tmr_ld_probe;
    logic  tmr_ld_cmd;
    logic  rtr_ld_cfg;
    logic  rtr_ld_cfg_m1;
    logic  rtr_dec;
    logic  page_clr;
    logic  page_inc;
    logic  word_clr;
    logic  word_inc;
    logic  low_ld;
    logic  hi_ld;
    logic  id_clr;
    logic  id_inc;
  } slbp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic tmr_one;
    logic rtr_one;
    logic cfg_rtr_zero;
    logic cfg_rtr_one;
    logic word_last;
    logic page_last;
    logic id_last;
  } slbp_status_t;

  function automatic logic [7:0] ident_byte(input logic [ID_W-1:0] a);
    return IDENT_ROM[ROM_BITS - 8 - 8 * int'(a) +: 8];
  endfunction

endpackage

@@ src/slbp_ctrl.sv @@
// Protocol controller: tracks the link mode and sequences the results of each item.
// Depends on slbp_pkg; drives slbp_dp through a command struct.
module slbp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  input  logic [7:0]           in_rx_byte,
  output logic                 in_stall,
  input  slbp_pkg::slbp_status_t status,
  output slbp_pkg::slbp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    M_START, M_PROBE, M_CMD, M_HEAD, M_LOW, M_HIGH, M_DONE
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_RUN, S_RWW_RUN, S_RWW_RETRY,
    S_ERASE, S_PAGE, S_FILL, S_WRITE, S_IDENT
  } seq_t;

  mode_t mode_r, mode_nxt;
  seq_t  seq_r, seq_nxt;
  logic  accept;

  assign in_stall = (seq_r != S_IDLE);
  assign accept   = in_valid && (seq_r == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.kind = slbp_pkg::K_SEND;
    cmd.bsrc = slbp_pkg::BS_NONE;
    seq_nxt  = seq_r;
    mode_nxt = mode_r;
    case (seq_r)
      S_IDLE: begin
        if (accept) begin
          case (mode_r)
            M_START: begin
              cmd.rtr_ld_cfg = 1'b1;
              seq_nxt = status.cfg_rtr_zero ? S_RUN : S_PROBE;
            end
            M_DONE: ;
            default: begin
              if (in_action) begin
                cmd.tmr_dec = 1'b1;
                if (status.tmr_one) begin
                  case (mode_r)
                    M_PROBE: begin
                      cmd.rtr_dec = 1'b1;
                      seq_nxt = status.rtr_one ? S_RUN : S_PROBE;
                    end
                    M_CMD:   seq_nxt = S_RUN;
                    M_HEAD:  seq_nxt = S_RWW_RUN;
                    default: seq_nxt = S_RWW_RETRY;
                  endcase
                end
              end else begin
                case (mode_r)
                  M_PROBE: begin
                    if (in_rx_byte != slbp_pkg::CH_ACK) begin
                      cmd.rtr_dec = 1'b1;
                      seq_nxt = status.rtr_one ? S_RUN : S_PROBE;
                    end else begin
                      cmd.tmr_ld_cmd = 1'b1;
                      mode_nxt = M_CMD;
                    end
                  end
                  M_CMD: begin
                    if (in_rx_byte == slbp_pkg::CH_IDENT) begin
                      cmd.tmr_ld_cmd = 1'b1;
                      cmd.id_clr = 1'b1;
                      if (!slbp_pkg::IDENT_EMPTY) seq_nxt = S_IDENT;
                    end else if (in_rx_byte == slbp_pkg::CH_WRITE) begin
                      cmd.tmr_ld_cmd = 1'b1;
                      cmd.page_clr = 1'b1;
                      mode_nxt = M_HEAD;
                      seq_nxt = S_ERASE;
                    end else begin
                      seq_nxt = S_RUN;
                    end
                  end
                  M_HEAD: begin
                    if (in_rx_byte == 8'h00) begin
                      seq_nxt = S_RWW_RUN;
                    end else begin
                      cmd.word_clr = 1'b1;
                      cmd.tmr_ld_cmd = 1'b1;
                      mode_nxt = M_LOW;
                    end
                  end
                  M_LOW: begin
                    cmd.low_ld = 1'b1;
                    cmd.tmr_ld_cmd = 1'b1;
                    mode_nxt = M_HIGH;
                  end
                  default: begin
                    cmd.hi_ld = 1'b1;
                    cmd.tmr_ld_cmd = 1'b1;
                    seq_nxt = S_FILL;
                  end
                endcase
              end
            end
          endcase
        end
      end
      S_PROBE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_SEND;
          cmd.bsrc = slbp_pkg::BS_PROBE;
          cmd.last = 1'b1;
          cmd.tmr_ld_probe = 1'b1;
          mode_nxt = M_PROBE;
          seq_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_RUN;
          cmd.last = 1'b1;
          mode_nxt = M_DONE;
          seq_nxt = S_IDLE;
        end
      end
      S_RWW_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_RWW;
          seq_nxt = S_RUN;
        end
      end
      S_RWW_RETRY: begin
        // Link lost in a page: emit RWW, reload retries, then probe or start app.
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_RWW;
          cmd.rtr_ld_cfg_m1 = 1'b1;
          seq_nxt = status.cfg_rtr_one ? S_RUN : S_PROBE;
        end
      end
      S_ERASE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_ERASE;
          seq_nxt = S_PAGE;
        end
      end
      S_PAGE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_SEND;
          cmd.bsrc = slbp_pkg::BS_PAGE;
          cmd.last = 1'b1;
          mode_nxt = M_HEAD;
          seq_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_FILL;
          cmd.word_inc = 1'b1;
          if (status.word_last) begin
            seq_nxt = S_WRITE;
          end else begin
            cmd.last = 1'b1;
            mode_nxt = M_LOW;
            seq_nxt = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_WRITE;
          cmd.page_inc = 1'b1;
          seq_nxt = status.page_last ? S_RWW_RUN : S_PAGE;
        end
      end
      S_IDENT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = slbp_pkg::K_SEND;
          cmd.bsrc = slbp_pkg::BS_IDENT;
          cmd.last = status.id_last;
          cmd.id_inc = 1'b1;
          if (status.id_last) seq_nxt = S_IDLE;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      seq_r  <= S_IDLE;
    end else begin
      mode_r <= mode_nxt;
      seq_r  <= seq_nxt;
    end
  end

endmodule

@@ src/slbp_dp.sv @@
// Datapath: configuration registers, timer, counters, held bytes and result register.
// Depends on slbp_pkg; controlled by slbp_ctrl through a command struct.
module slbp_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  slbp_pkg::slbp_cmd_t                   cmd,
  output slbp_pkg::slbp_status_t                status,
  input  logic [7:0]                            in_rx_byte,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [slbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slbp_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            out_kind,
  output logic [7:0]                            out_byte,
  output logic [15:0]                           out_data_word,
  output logic [slbp_pkg::ADDR_W-1:0]           out_flash_address,
  output logic                                  out_last_of_run
);

  logic [15:0]                   probe_win_r;
  logic [15:0]                   cmd_wait_r;
  logic [7:0]                    retry_cnt_r;
  logic [15:0]                   tmr_r;
  logic [7:0]                    rtr_r;
  logic [slbp_pkg::PAGE_W-1:0]   page_r;
  logic [slbp_pkg::WORD_W-1:0]   word_r;
  logic [slbp_pkg::ID_W-1:0]     id_r;
  logic [7:0]                    low_r;
  logic [7:0]                    hi_r;

  logic                          out_valid_r;
  slbp_pkg::kind_t               kind_r;
  logic [7:0]                    byte_r;
  logic [15:0]                   word_out_r;
  logic [slbp_pkg::ADDR_W-1:0]   addr_r;
  logic                          last_r;

  logic [7:0]                    byte_sel;
  logic [15:0]                   word_sel;
  logic [slbp_pkg::ADDR_W-1:0]   addr_sel;

  assign cfg_ready = 1'b1;

  assign status.out_free     = !out_valid_r || !out_stall;
  assign status.tmr_one      = (tmr_r == 16'd1);
  assign status.rtr_one      = (rtr_r == 8'd1);
  assign status.cfg_rtr_zero = (retry_cnt_r == 8'd0);
  assign status.cfg_rtr_one  = (retry_cnt_r == 8'd1);
  assign status.word_last    = (word_r == slbp_pkg::WORD_W'(slbp_pkg::PAGE_WORDS - 1));
  assign status.page_last    = (page_r == slbp_pkg::PAGE_W'(slbp_pkg::PAGE_COUNT - 1));
  // The stream ends at the limit or just before the next zero byte.
  assign status.id_last =
    (id_r == slbp_pkg::ID_W'(slbp_pkg::IDENT_LIMIT - 1)) ||
    (slbp_pkg::ident_byte(slbp_pkg::ID_W'(id_r + 1'b1)) == 8'h00);

  always_comb begin
    case (cmd.bsrc)
      slbp_pkg::BS_PROBE: byte_sel = slbp_pkg::CH_PROBE;
      slbp_pkg::BS_PAGE:  byte_sel = slbp_pkg::CH_PAGE;
      slbp_pkg::BS_IDENT: byte_sel = slbp_pkg::ident_byte(id_r);
      default:            byte_sel = 8'h00;
    endcase
    word_sel = 16'h0000;
    addr_sel = '0;
    case (cmd.kind)
      slbp_pkg::K_FILL: begin
        word_sel = {hi_r, low_r};
        addr_sel = slbp_pkg::ADDR_W'({word_r, 1'b0});
      end
      slbp_pkg::K_WRITE: begin
        addr_sel = slbp_pkg::ADDR_W'(page_r * slbp_pkg::PAGE_BYTES);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_win_r <= slbp_pkg::PROBE_WINDOW_RST;
      cmd_wait_r  <= slbp_pkg::COMMAND_WAIT_RST;
      retry_cnt_r <= slbp_pkg::RETRY_COUNT_RST;
      tmr_r       <= '0;
      rtr_r       <= '0;
      page_r      <= '0;
      word_r      <= '0;
      id_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          slbp_pkg::REG_PROBE_WINDOW: probe_win_r <= cfg_data;
          slbp_pkg::REG_COMMAND_WAIT: cmd_wait_r  <= cfg_data;
          slbp_pkg::REG_RETRY_COUNT:  retry_cnt_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.tmr_ld_probe)    tmr_r <= probe_win_r;
      else if (cmd.tmr_ld_cmd) tmr_r <= cmd_wait_r;
      else if (cmd.tmr_dec)    tmr_r <= tmr_r - 16'd1;
      if (cmd.rtr_ld_cfg)         rtr_r <= retry_cnt_r;
      else if (cmd.rtr_ld_cfg_m1) rtr_r <= retry_cnt_r - 8'd1;
      else if (cmd.rtr_dec)       rtr_r <= rtr_r - 8'd1;
      if (cmd.page_clr)      page_r <= '0;
      else if (cmd.page_inc) page_r <= page_r + 1'b1;
      if (cmd.word_clr)      word_r <= '0;
      else if (cmd.word_inc) word_r <= word_r + 1'b1;
      if (cmd.id_clr)        id_r <= '0;
      else if (cmd.id_inc)   id_r <= id_r + 1'b1;
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.low_ld) low_r <= in_rx_byte;
    if (cmd.hi_ld)  hi_r  <= in_rx_byte;
    if (cmd.emit) begin
      kind_r     <= cmd.kind;
      byte_r     <= byte_sel;
      word_out_r <= word_sel;
      addr_r     <= addr_sel;
      last_r     <= cmd.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_byte          = byte_r;
  assign out_data_word     = word_out_r;
  assign out_flash_address = addr_r;
  assign out_last_of_run   = last_r;

endmodule

@@ src/serial_boot_loader_protocol.sv @@
// Top level of the serial boot loader protocol engine.
// Depends on slbp_pkg, slbp_ctrl, slbp_dp and the assertion macro header.
//
// Input channel: each beat is either a received byte (in_action = 0, byte on
// in_rx_byte) or one elapsed character time (in_action = 1). Result channel:
// one beat per action (send byte, erase, page fill, page write, enable read
// section, start application); out_last_of_run marks the final beat of the
// results caused by one input beat. Configuration writes (probe window,
// command wait, retry count) are always accepted through cfg_valid/cfg_ready.
// Sequencing: an input beat is taken while the sequencer is idle; the results
// it causes then follow one by one, from 0 to 4 of them, or up to the
// identification length (30 bytes) for the 'i' command. The result
// sequencer in slbp_ctrl emits one result per cycle while the output is not
// stalled, through a single output register, and takes no new input until
// the run is out. A stalled output beat holds the register, and the sequencer
// if more results follow, until taken (in_stall high). Reset restores the register
// defaults and the start mode: the first input beat then sends the first '?' probe.
`include "serial_boot_loader_protocol_assert.svh"

module serial_boot_loader_protocol (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_kind,
  output logic [7:0]                       out_byte,
  output logic [15:0]                      out_data_word,
  output logic [slbp_pkg::ADDR_W-1:0]      out_flash_address,
  output logic                             out_last_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  slbp_pkg::slbp_cmd_t    cmd;
  slbp_pkg::slbp_status_t status;

  slbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  slbp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_rx_byte        (in_rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_data_word     (out_data_word),
    .out_flash_address (out_flash_address),
    .out_last_of_run   (out_last_of_run)
  );

  // A result is only issued when the output register can take it.
  `SLBP_ASSERT_IMP(a_emit_free, cmd.emit, status.out_free)
  // An issued result shows up on the output in the next cycle.
  `SLBP_ASSERT_NXT(a_emit_shows, cmd.emit, out_valid)
  // Nothing is issued in the cycle an input beat is taken.
  `SLBP_ASSERT_IMP(a_no_emit_on_take, in_valid && !in_stall, !cmd.emit)
  // Starting the application always closes the run.
  `SLBP_ASSERT_IMP(a_run_is_last, out_valid && (out_kind == slbp_pkg::K_RUN), out_last_of_run)

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the serial boot loader protocol engine: probing,
// identification, erase and page loading, with a predictor and random stalls.
// Depends on slbp_pkg and the serial_boot_loader_protocol top level only.
module tb_top;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int SETTLE_CYCLES   = 8;
  localparam int FINAL_WAIT      = 20000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDENT_SLOTS     = 32;
  localparam int MAX_RUN         = 64;

  localparam logic [IDENT_SLOTS*8-1:0] IDENT_IMAGE =
    {8'h0d, 8'h0a, "&128,32768,m32,16000000,1*", 8'h0d, 8'h0a, 16'h0000};

  typedef enum logic [2:0] {
    LD_START, LD_PROBE, LD_CMD, LD_HEAD, LD_LOW, LD_HIGH, LD_DONE
  } loader_mode_t;

  typedef enum {
    END_BAD_COMMAND, END_COMMAND_TIMEOUT, END_ZERO_PAGE,
    END_PAGE_TIMEOUT, END_RETRIES_OUT, END_LINK_LOST
  } ending_t;

  typedef struct {
    slbp_pkg::kind_t kind;
    logic [7:0]      tx_byte;
    logic [15:0]     data_word;
    logic [14:0]     addr;
    logic            last;
  } loader_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_action = 1'b0;
  logic [7:0]                      in_rx_byte = 8'h00;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [2:0]                      out_kind;
  logic [7:0]                      out_byte;
  logic [15:0]                     out_data_word;
  logic [slbp_pkg::ADDR_W-1:0]     out_flash_address;
  logic                            out_last_of_run;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [slbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [slbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted state of the engine and its register copies.
  loader_mode_t loader_mode = LD_START;
  logic [15:0]  wait_timer = '0;
  logic [7:0]   probes_left = '0;
  int           page_index = 0;
  int           word_index = 0;
  logic [7:0]   low_byte_held = '0;
  logic [15:0]  probe_window = slbp_pkg::PROBE_WINDOW_RST;
  logic [15:0]  command_wait = slbp_pkg::COMMAND_WAIT_RST;
  logic [7:0]   retry_limit = slbp_pkg::RETRY_COUNT_RST;

  loader_result_t pending_results[$];
  loader_result_t run_buf[MAX_RUN];
  int             run_len;

  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      cycle_count = 0;
  int      mismatches = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      pages_written = 0;
  logic    last_was_tick = 1'b0;
  ending_t ending_kind = END_BAD_COMMAND;

  serial_boot_loader_protocol uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_data_word     (out_data_word),
    .out_flash_address (out_flash_address),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    loader_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind=%0d byte=%h word=%h addr=%h last=%b",
                   out_kind, out_byte, out_data_word, out_flash_address, out_last_of_run);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_kind != want.kind || out_byte != want.tx_byte ||
            out_data_word != want.data_word || out_flash_address != want.addr ||
            out_last_of_run != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind=%0d byte=%h word=%h addr=%h last=%b, %s",
                     want.kind, want.tx_byte, want.data_word, want.addr, want.last,
                     $sformatf("got kind=%0d byte=%h word=%h addr=%h last=%b",
                               out_kind, out_byte, out_data_word, out_flash_address,
                               out_last_of_run));
        end
      end
    end
  end

  function automatic void note_result(slbp_pkg::kind_t k, logic [7:0] b, logic [15:0] w,
                                      logic [31:0] a);
    if (run_len < MAX_RUN) begin
      run_buf[run_len] = '{kind: k, tx_byte: b, data_word: w, addr: a[14:0], last: 1'b0};
      run_len++;
    end
  endfunction

  function automatic void start_application();
    loader_mode = LD_DONE;
    note_result(slbp_pkg::K_RUN, 8'h00, 16'h0000, 0);
  endfunction

  function automatic void send_probe();
    loader_mode = LD_PROBE;
    wait_timer = probe_window;
    note_result(slbp_pkg::K_SEND, slbp_pkg::CH_PROBE, 16'h0000, 0);
  endfunction

  function automatic void probe_failed();
    probes_left = probes_left - 8'd1;
    if (probes_left == 8'd0)
      start_application();
    else
      send_probe();
  endfunction

  function automatic void finish_load();
    note_result(slbp_pkg::K_RWW, 8'h00, 16'h0000, 0);
    start_application();
  endfunction

  // Works out the result beats that one accepted input beat causes.
  function automatic void advance_loader(logic tick, logic [7:0] b);
    logic [7:0] rom_byte;
    run_len = 0;
    if (loader_mode == LD_START) begin
      probes_left = retry_limit;
      if (probes_left == 8'd0)
        start_application();
      else
        send_probe();
    end else if (loader_mode != LD_DONE) begin
      if (tick) begin
        wait_timer = wait_timer - 16'd1;
        if (wait_timer == 16'd0) begin
          case (loader_mode)
            LD_PROBE: probe_failed();
            LD_CMD: start_application();
            LD_HEAD: finish_load();
            LD_LOW, LD_HIGH: begin
              // Link lost inside a page: release the read section, probe again or start the application.
              note_result(slbp_pkg::K_RWW, 8'h00, 16'h0000, 0);
              probes_left = retry_limit - 8'd1;
              if (probes_left == 8'd0)
                start_application();
              else
                send_probe();
            end
            default: ;
          endcase
        end
      end else begin
        case (loader_mode)
          LD_PROBE: begin
            if (b != slbp_pkg::CH_ACK) begin
              probe_failed();
            end else begin
              loader_mode = LD_CMD;
              wait_timer = command_wait;
            end
          end
          LD_CMD: begin
            if (b == slbp_pkg::CH_IDENT) begin
              for (int i = 0; i < slbp_pkg::IDENT_LENGTH && i < IDENT_SLOTS; i++) begin
                rom_byte = IDENT_IMAGE[IDENT_SLOTS*8 - 1 - 8*i -: 8];
                if (rom_byte == 8'h00)
                  break;
                note_result(slbp_pkg::K_SEND, rom_byte, 16'h0000, 0);
              end
              wait_timer = command_wait;
            end else if (b == slbp_pkg::CH_WRITE) begin
              note_result(slbp_pkg::K_ERASE, 8'h00, 16'h0000, 0);
              page_index = 0;
              loader_mode = LD_HEAD;
              wait_timer = command_wait;
              note_result(slbp_pkg::K_SEND, slbp_pkg::CH_PAGE, 16'h0000, 0);
            end else begin
              start_application();
            end
          end
          LD_HEAD: begin
            if (b == 8'h00) begin
              finish_load();
            end else begin
              word_index = 0;
              loader_mode = LD_LOW;
              wait_timer = command_wait;
            end
          end
          LD_LOW: begin
            low_byte_held = b;
            loader_mode = LD_HIGH;
            wait_timer = command_wait;
          end
          LD_HIGH: begin
            note_result(slbp_pkg::K_FILL, 8'h00, {b, low_byte_held}, word_index * 2);
            word_index++;
            wait_timer = command_wait;
            if (word_index < slbp_pkg::PAGE_WORDS) begin
              loader_mode = LD_LOW;
            end else begin
              note_result(slbp_pkg::K_WRITE, 8'h00, 16'h0000,
                          page_index * slbp_pkg::PAGE_WORDS * 2);
              pages_written++;
              page_index++;
              if (page_index < slbp_pkg::PAGE_COUNT) begin
                loader_mode = LD_HEAD;
                note_result(slbp_pkg::K_SEND, slbp_pkg::CH_PAGE, 16'h0000, 0);
              end else begin
                finish_load();
              end
            end
          end
          default: ;
        endcase
      end
    end
    for (int i = 0; i < run_len; i++) begin
      run_buf[i].last = (i == run_len - 1);
      pending_results.push_back(run_buf[i]);
    end
  endfunction

  // Valid stays high after a beat is taken unless the next beat is preceded by a gap.
  task automatic send_item(input logic tick, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_action  <= tick;
    in_rx_byte <= b;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    advance_loader(tick, b);
    last_was_tick = tick;
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      slbp_pkg::REG_PROBE_WINDOW: probe_window = value;
      slbp_pkg::REG_COMMAND_WAIT: command_wait = value;
      slbp_pkg::REG_RETRY_COUNT:  retry_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [15:0] probe, input logic [15:0] cmd,
                               input logic [7:0] retries);
    wait_idle();
    write_reg(slbp_pkg::REG_PROBE_WINDOW, probe);
    write_reg(slbp_pkg::REG_COMMAND_WAIT, cmd);
    write_reg(slbp_pkg::REG_RETRY_COUNT, {8'h00, retries});
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed protocol traffic; steers clear of starting the
  // application, which would end the session for good.
  function automatic void pick_item(output logic tick, output logic [7:0] b);
    int r;
    r = $urandom_range(0, 99);
    tick = 1'b0;
    b = 8'($urandom_range(0, 255));
    case (loader_mode)
      LD_PROBE: begin
        if (probes_left > 8'd1 && r < 15)
          tick = 1'b1;
        else if (probes_left <= 8'd1 || r >= 25)
          b = slbp_pkg::CH_ACK;
      end
      LD_CMD: begin
        if (r < 10 && wait_timer != 16'd1)
          tick = 1'b1;
        else if (r < 35)
          b = slbp_pkg::CH_IDENT;
        else
          b = slbp_pkg::CH_WRITE;
      end
      LD_HEAD: begin
        if (r < 10 && wait_timer != 16'd1)
          tick = 1'b1;
        else
          b = 8'($urandom_range(1, 255));
      end
      LD_LOW, LD_HIGH: begin
        // Ticks come in bursts so that mid-page timeouts actually happen.
        if ((last_was_tick ? r < 80 : r < 5) &&
            !(wait_timer == 16'd1 && retry_limit == 8'd1))
          tick = 1'b1;
      end
      default: tick = r[0];
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct = 6;
    recv_idle_pct = 88;
    set_registers(16'd3, 16'd4, 8'd255);
    send_item(1'b1, 8'h5a);          // first beat sends the first probe
    send_item(1'b0, 8'h00);          // wrong reply to the probe
    repeat (3) send_item(1'b1, 8'hff);
    send_item(1'b0, slbp_pkg::CH_ACK);
    send_item(1'b0, slbp_pkg::CH_IDENT);
    send_item(1'b1, 8'h00);
    send_item(1'b0, slbp_pkg::CH_WRITE);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    repeat (4) send_item(1'b1, 8'h00);
    // A retry count of zero wraps to 255 when the link drops inside a page.
    set_registers(16'd3, 16'd4, 8'd0);
    send_item(1'b0, slbp_pkg::CH_ACK);
    send_item(1'b0, slbp_pkg::CH_WRITE);
    send_item(1'b0, 8'h80);
    repeat (4) send_item(1'b1, 8'h7f);
  endtask

  task automatic test_random_traffic(input int phase);
    logic       tick;
    logic [7:0] b;
    case (phase)
      0: begin
        send_idle_pct = 6;
        recv_idle_pct = 88;
        set_registers(16'($urandom_range(1, 4)), 16'($urandom_range(2, 6)),
                      8'($urandom_range(2, 8)));
      end
      1: begin
        send_idle_pct = 88;
        recv_idle_pct = 6;
        set_registers(16'd1, 16'd1, 8'd255);
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(16'hffff, 16'h0000, 8'd0);
      end
    endcase
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      pick_item(tick, b);
      send_item(tick, b);
    end
  endtask

  task automatic test_terminal_case();
    logic [7:0] b;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(16'd2, 16'd3, 8'd3);
    ending_kind = ending_t'($urandom_range(0, 5));
    while (loader_mode != LD_CMD) begin
      b = 8'($urandom_range(0, 255));
      case (loader_mode)
        LD_HEAD: send_item(1'b0, 8'h01);
        LD_LOW, LD_HIGH: begin
          // A byte first reloads the short command wait, then ticks drop the link.
          if (wait_timer != 16'd0 && wait_timer <= 16'd3)
            send_item(1'b1, b);
          else
            send_item(1'b0, b);
        end
        default: send_item(1'b0, slbp_pkg::CH_ACK);
      endcase
    end
    case (ending_kind)
      END_BAD_COMMAND: begin
        b = 8'($urandom_range(0, 255));
        if (b == slbp_pkg::CH_IDENT || b == slbp_pkg::CH_WRITE)
          b = 8'h00;
        send_item(1'b0, b);
      end
      END_COMMAND_TIMEOUT: send_item(1'b0, slbp_pkg::CH_IDENT);
      END_ZERO_PAGE: begin
        send_item(1'b0, slbp_pkg::CH_WRITE);
        send_item(1'b0, 8'h00);
      end
      END_PAGE_TIMEOUT: send_item(1'b0, slbp_pkg::CH_WRITE);
      END_RETRIES_OUT: begin
        send_item(1'b0, slbp_pkg::CH_WRITE);
        send_item(1'b0, 8'h01);
      end
      default: begin
        set_registers(16'd2, 16'd3, 8'd1);
        send_item(1'b0, slbp_pkg::CH_WRITE);
        send_item(1'b0, 8'h01);
      end
    endcase
    while (loader_mode != LD_DONE) begin
      b = 8'($urandom_range(0, 255));
      if (loader_mode == LD_PROBE && $urandom_range(0, 1) == 1) begin
        if (b == slbp_pkg::CH_ACK)
          b = 8'h00;
        send_item(1'b0, b);
      end else begin
        send_item(1'b1, b);
      end
    end
  endtask

  task automatic test_ignored_after_start();
    repeat (12) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  initial begin : run_tests
    int waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int phase = 0; phase < 3; phase++)
      test_random_traffic(phase);
    test_terminal_case();
    test_ignored_after_start();
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < FINAL_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d expected result beats never arrived", pending_results.size());
    end
    $display("Sent %0d input beats and checked %0d result beats; %0d flash pages written.",
             items_sent, results_checked, pages_written);
    $display("The session ended by %s, with %0d mismatches.", ending_kind.name(), mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
